// ===== rtl/complex_arith_unit_defines.svh =====
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// Implication checked out of reset.
`define CAU_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Implication checked during reset as well.
`define CAU_ASSERT_ANY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |-> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/cau_pkg.sv =====
// Types, codes and helpers shared by the complex arithmetic unit.
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CELLS     = 32;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_DIST = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_SAT     = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] first_real;
    logic signed [31:0] first_imag;
    logic signed [31:0] second_real;
    logic signed [31:0] second_imag;
    logic [2:0]         operation;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clamp_t;

  typedef struct packed {
    logic        vld;
    logic [2:0]  op;
    logic [31:0] erly_re;
    logic [31:0] erly_im;
    logic        erly_sat;
    logic        zden;
    logic        mbig;
    logic        neg_re;
    logic        ovf_re;
    logic [63:0] rem_re;
    logic [31:0] dlo_re;
    logic [31:0] q_re;
    logic        neg_im;
    logic        ovf_im;
    logic [63:0] rem_im;
    logic [31:0] dlo_im;
    logic [31:0] q_im;
    logic [63:0] den;
    logic [63:0] sq_n;
    logic [35:0] sq_rem;
    logic [31:0] sq_root;
  } cell_t;

  function automatic clamp_t clamp65(input logic signed [64:0] v);
    clamp_t r;
    if (v > 65'sd2147483647) begin
      r.val = 32'h7FFF_FFFF;
      r.sat = 1'b1;
    end else if (v < -65'sd2147483648) begin
      r.val = 32'h8000_0000;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/cau_front.sv =====
// Front pipeline: sums, products, numerators and divider and root setup.
module cau_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  cau_pkg::in_word_t in_word,
  output cau_pkg::cell_t   cell_o
);

  localparam int DW = 64 + cau_pkg::FRAC_BITS;

  logic              s0_vld_r;
  cau_pkg::in_word_t s0_w_r;
  logic signed [32:0] s0_sre_r, s0_sim_r, s0_dre_r, s0_dim_r;

  logic               s1_vld_r;
  logic [2:0]         s1_op_r;
  logic signed [63:0] s1_ac_r, s1_bd_r, s1_ad_r, s1_bc_r, s1_cc_r, s1_dd_r;
  logic [61:0]        s1_dx2_r, s1_dy2_r;
  logic               s1_mbig_r;
  logic signed [32:0] s1_sre_r, s1_sim_r, s1_dre_r, s1_dim_r;
  logic signed [65:0] dx2_w, dy2_w;
  logic               bigx_w, bigy_w;

  logic               s2_vld_r;
  logic [2:0]         s2_op_r;
  logic signed [64:0] s2_nre_r, s2_nim_r;
  logic [63:0]        s2_den_r;
  logic [62:0]        s2_sq_r;
  logic               s2_mbig_r;
  logic [31:0]        s2_ere_r, s2_eim_r;
  logic               s2_esat_r;
  logic signed [64:0] mre_w, mim_w;
  cau_pkg::clamp_t    cre_w, cim_w;

  logic               s3_vld_r;
  logic [2:0]         s3_op_r;
  logic [63:0]        s3_mre_r, s3_mim_r;
  logic               s3_nre_r, s3_nim_r;
  logic [63:0]        s3_den_r;
  logic               s3_zden_r;
  logic [62:0]        s3_sq_r;
  logic               s3_mbig_r;
  logic [31:0]        s3_ere_r, s3_eim_r;
  logic               s3_esat_r;
  logic signed [64:0] nre_neg_w, nim_neg_w;

  logic [DW-1:0]      dre_w, dim_w;
  logic [DW-33:0]     r0re_w, r0im_w;
  cau_pkg::cell_t     c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      c_r.vld  <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_vld;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      c_r.vld  <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_w_r   <= in_word;
      s0_sre_r <= 33'(in_word.first_real) + 33'(in_word.second_real);
      s0_sim_r <= 33'(in_word.first_imag) + 33'(in_word.second_imag);
      s0_dre_r <= 33'(in_word.first_real) - 33'(in_word.second_real);
      s0_dim_r <= 33'(in_word.first_imag) - 33'(in_word.second_imag);
    end
  end

  assign dx2_w  = s0_dre_r * s0_dre_r;
  assign dy2_w  = s0_dim_r * s0_dim_r;
  assign bigx_w = !(s0_dre_r[32:31] == 2'b00 ||
                    (s0_dre_r[32:31] == 2'b11 && s0_dre_r[30:0] != 31'd0));
  assign bigy_w = !(s0_dim_r[32:31] == 2'b00 ||
                    (s0_dim_r[32:31] == 2'b11 && s0_dim_r[30:0] != 31'd0));

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r   <= s0_w_r.operation;
      s1_ac_r   <= s0_w_r.first_real * s0_w_r.second_real;
      s1_bd_r   <= s0_w_r.first_imag * s0_w_r.second_imag;
      s1_ad_r   <= s0_w_r.first_real * s0_w_r.second_imag;
      s1_bc_r   <= s0_w_r.first_imag * s0_w_r.second_real;
      s1_cc_r   <= s0_w_r.second_real * s0_w_r.second_real;
      s1_dd_r   <= s0_w_r.second_imag * s0_w_r.second_imag;
      s1_dx2_r  <= dx2_w[61:0];
      s1_dy2_r  <= dy2_w[61:0];
      s1_mbig_r <= bigx_w || bigy_w;
      s1_sre_r  <= s0_sre_r;
      s1_sim_r  <= s0_sim_r;
      s1_dre_r  <= s0_dre_r;
      s1_dim_r  <= s0_dim_r;
    end
  end

  assign mre_w = (65'(s1_ac_r) - 65'(s1_bd_r)) >>> cau_pkg::FRAC_BITS;
  assign mim_w = (65'(s1_ad_r) + 65'(s1_bc_r)) >>> cau_pkg::FRAC_BITS;

  always_comb begin
    case (s1_op_r)
      cau_pkg::OP_ADD: begin
        cre_w = cau_pkg::clamp65(65'(s1_sre_r));
        cim_w = cau_pkg::clamp65(65'(s1_sim_r));
      end
      cau_pkg::OP_SUB: begin
        cre_w = cau_pkg::clamp65(65'(s1_dre_r));
        cim_w = cau_pkg::clamp65(65'(s1_dim_r));
      end
      cau_pkg::OP_MUL: begin
        cre_w = cau_pkg::clamp65(mre_w);
        cim_w = cau_pkg::clamp65(mim_w);
      end
      default: begin
        cre_w = '0;
        cim_w = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op_r   <= s1_op_r;
      s2_nre_r  <= 65'(s1_ac_r) + 65'(s1_bd_r);
      s2_nim_r  <= 65'(s1_bc_r) - 65'(s1_ad_r);
      s2_den_r  <= $unsigned(s1_cc_r) + $unsigned(s1_dd_r);
      s2_sq_r   <= {1'b0, s1_dx2_r} + {1'b0, s1_dy2_r};
      s2_mbig_r <= s1_mbig_r;
      s2_ere_r  <= cre_w.val;
      s2_eim_r  <= cim_w.val;
      s2_esat_r <= cre_w.sat || cim_w.sat;
    end
  end

  assign nre_neg_w = -s2_nre_r;
  assign nim_neg_w = -s2_nim_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_op_r   <= s2_op_r;
      s3_nre_r  <= s2_nre_r[64];
      s3_nim_r  <= s2_nim_r[64];
      s3_mre_r  <= s2_nre_r[64] ? nre_neg_w[63:0] : s2_nre_r[63:0];
      s3_mim_r  <= s2_nim_r[64] ? nim_neg_w[63:0] : s2_nim_r[63:0];
      s3_den_r  <= s2_den_r;
      s3_zden_r <= (s2_den_r == 64'd0);
      s3_sq_r   <= s2_sq_r;
      s3_mbig_r <= s2_mbig_r;
      s3_ere_r  <= s2_ere_r;
      s3_eim_r  <= s2_eim_r;
      s3_esat_r <= s2_esat_r;
    end
  end

  assign dre_w  = {s3_mre_r, {cau_pkg::FRAC_BITS{1'b0}}};
  assign dim_w  = {s3_mim_r, {cau_pkg::FRAC_BITS{1'b0}}};
  assign r0re_w = dre_w[DW-1:32];
  assign r0im_w = dim_w[DW-1:32];

  always_ff @(posedge clk) begin
    if (en) begin
      c_r.op       <= s3_op_r;
      c_r.erly_re  <= s3_ere_r;
      c_r.erly_im  <= s3_eim_r;
      c_r.erly_sat <= s3_esat_r;
      c_r.zden     <= s3_zden_r;
      c_r.mbig     <= s3_mbig_r;
      c_r.neg_re   <= s3_nre_r;
      c_r.ovf_re   <= (64'(r0re_w) >= s3_den_r);
      c_r.rem_re   <= 64'(r0re_w);
      c_r.dlo_re   <= dre_w[31:0];
      c_r.q_re     <= '0;
      c_r.neg_im   <= s3_nim_r;
      c_r.ovf_im   <= (64'(r0im_w) >= s3_den_r);
      c_r.rem_im   <= 64'(r0im_w);
      c_r.dlo_im   <= dim_w[31:0];
      c_r.q_im     <= '0;
      c_r.den      <= s3_den_r;
      c_r.sq_n     <= {1'b0, s3_sq_r};
      c_r.sq_rem   <= '0;
      c_r.sq_root  <= '0;
    end
  end

  assign cell_o = c_r;

endmodule

// ===== rtl/cau_cell.sv =====
// One step of both divider lanes and of the square root.
module cau_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cau_pkg::cell_t cell_i,
  output cau_pkg::cell_t cell_o
);

  cau_pkg::cell_t c_r, c_nxt;
  logic [64:0] rre_w, rim_w, dext_w;
  logic        gre_w, gim_w;
  logic [35:0] sr_w, trial_w;
  logic        gsq_w;

  always_comb begin
    c_nxt   = cell_i;
    dext_w  = {1'b0, cell_i.den};
    rre_w   = {cell_i.rem_re, cell_i.dlo_re[31]};
    rim_w   = {cell_i.rem_im, cell_i.dlo_im[31]};
    gre_w   = (rre_w >= dext_w);
    gim_w   = (rim_w >= dext_w);
    sr_w    = {cell_i.sq_rem[33:0], cell_i.sq_n[63:62]};
    trial_w = {2'b00, cell_i.sq_root, 2'b01};
    gsq_w   = (sr_w >= trial_w);

    c_nxt.rem_re = gre_w ? 64'(rre_w - dext_w) : rre_w[63:0];
    c_nxt.rem_im = gim_w ? 64'(rim_w - dext_w) : rim_w[63:0];
    c_nxt.q_re   = {cell_i.q_re[30:0], gre_w};
    c_nxt.q_im   = {cell_i.q_im[30:0], gim_w};
    c_nxt.dlo_re = {cell_i.dlo_re[30:0], 1'b0};
    c_nxt.dlo_im = {cell_i.dlo_im[30:0], 1'b0};

    c_nxt.sq_rem  = gsq_w ? (sr_w - trial_w) : sr_w;
    c_nxt.sq_root = {cell_i.sq_root[30:0], gsq_w};
    c_nxt.sq_n    = {cell_i.sq_n[61:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else if (en) begin
      c_r.vld <= c_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r.op       <= c_nxt.op;
      c_r.erly_re  <= c_nxt.erly_re;
      c_r.erly_im  <= c_nxt.erly_im;
      c_r.erly_sat <= c_nxt.erly_sat;
      c_r.zden     <= c_nxt.zden;
      c_r.mbig     <= c_nxt.mbig;
      c_r.neg_re   <= c_nxt.neg_re;
      c_r.ovf_re   <= c_nxt.ovf_re;
      c_r.rem_re   <= c_nxt.rem_re;
      c_r.dlo_re   <= c_nxt.dlo_re;
      c_r.q_re     <= c_nxt.q_re;
      c_r.neg_im   <= c_nxt.neg_im;
      c_r.ovf_im   <= c_nxt.ovf_im;
      c_r.rem_im   <= c_nxt.rem_im;
      c_r.dlo_im   <= c_nxt.dlo_im;
      c_r.q_im     <= c_nxt.q_im;
      c_r.den      <= c_nxt.den;
      c_r.sq_n     <= c_nxt.sq_n;
      c_r.sq_rem   <= c_nxt.sq_rem;
      c_r.sq_root  <= c_nxt.sq_root;
    end
  end

  assign cell_o = c_r;

endmodule

// ===== rtl/cau_back.sv =====
// Result stage: quotient and root limits, operation select, output register.
module cau_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  cau_pkg::cell_t     cell_i,
  output logic               out_valid,
  output cau_pkg::out_word_t out_word
);

  logic               vld_r;
  cau_pkg::out_word_t word_r, word_nxt;
  logic [31:0]        lre_w, lim_w, qre_w, qim_w, vre_w, vim_w, root_w;
  logic               sre_w, sim_w, srt_w, sat_w;

  always_comb begin
    lre_w = cell_i.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF;
    lim_w = cell_i.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sre_w = cell_i.ovf_re || (cell_i.q_re > lre_w);
    sim_w = cell_i.ovf_im || (cell_i.q_im > lim_w);
    qre_w = sre_w ? lre_w : cell_i.q_re;
    qim_w = sim_w ? lim_w : cell_i.q_im;
    vre_w = cell_i.neg_re ? (32'd0 - qre_w) : qre_w;
    vim_w = cell_i.neg_im ? (32'd0 - qim_w) : qim_w;

    srt_w  = cell_i.mbig || cell_i.sq_root[31];
    root_w = srt_w ? 32'h7FFF_FFFF : cell_i.sq_root;

    word_nxt = '0;
    sat_w    = 1'b0;
    case (cell_i.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
        word_nxt.result_real = cell_i.erly_re;
        word_nxt.result_imag = cell_i.erly_im;
        sat_w                = cell_i.erly_sat;
      end
      cau_pkg::OP_DIV: begin
        if (!cell_i.zden) begin
          word_nxt.result_real = vre_w;
          word_nxt.result_imag = vim_w;
          sat_w                = sre_w || sim_w;
        end
      end
      cau_pkg::OP_DIST: begin
        word_nxt.result_real = root_w;
        sat_w                = srt_w;
      end
      default: begin
        sat_w = 1'b0;
      end
    endcase

    if (cell_i.op == cau_pkg::OP_DIV && cell_i.zden) begin
      word_nxt.status = cau_pkg::ST_DIVZERO;
    end else if (sat_w) begin
      word_nxt.status = cau_pkg::ST_SAT;
    end else begin
      word_nxt.status = cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= cell_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_word  = word_r;

endmodule

// ===== rtl/complex_arith_unit.sv =====
// Throughput: one word per cycle; five front stages, a chain of 32 divide/root cells
// (one quotient bit and one root bit per cell), one output register.
// The whole pipeline holds while an output word is stalled.
// Reset: synchronous, active low; clears all stage valid flags, payload is not reset.
`include "complex_arith_unit_defines.svh"
module complex_arith_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cau_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output cau_pkg::out_word_t out_word
);

  logic           en;
  cau_pkg::cell_t chain [0:cau_pkg::CELLS];

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  cau_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .in_word(in_word),
    .cell_o (chain[0])
  );

  for (genvar i = 0; i < cau_pkg::CELLS; i++) begin : g_cell
    cau_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .cell_i(chain[i]),
      .cell_o(chain[i+1])
    );
  end

  cau_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cell_i   (chain[cau_pkg::CELLS]),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  `CAU_ASSERT_IMP(a_divzero_zero, out_valid && out_word.status == cau_pkg::ST_DIVZERO, out_word.result_real == 32'd0 && out_word.result_imag == 32'd0)
  `CAU_ASSERT_ANY(a_reset_empty, $past(!rst_n), !out_valid)

endmodule

// ===== tb/complex_arith_unit_tb.sv =====
// Self-checking testbench for the complex arithmetic unit: directed and random words.
module complex_arith_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_WORDS = 1750;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  cau_pkg::in_word_t in_word;
  logic out_valid;
  logic out_stall;
  cau_pkg::out_word_t out_word;

  cau_pkg::out_word_t expected_results[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  int op_count[8];
  bit quiet = 1'b0;

  complex_arith_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("complex_arith_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] clip(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] scaled_quotient(input logic signed [127:0] num,
                                                  input logic signed [127:0] den,
                                                  inout logic sat);
    logic neg;
    logic signed [127:0] mag, q, limit;
    neg = num < 0;
    mag = neg ? -num : num;
    mag = mag <<< cau_pkg::FRAC_BITS;
    q = mag / den;
    limit = neg ? 128'sd2147483648 : 128'sd2147483647;
    if (q > limit) begin
      q = limit;
      sat = 1'b1;
    end
    q = neg ? -q : q;
    return q[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic cau_pkg::out_word_t predict_result(input cau_pkg::in_word_t w);
    cau_pkg::out_word_t r;
    logic signed [127:0] a, b, c, d, den, dx, dy;
    logic [63:0] root;
    logic sat;
    a = w.first_real;
    b = w.first_imag;
    c = w.second_real;
    d = w.second_imag;
    sat = 1'b0;
    r.result_real = '0;
    r.result_imag = '0;
    r.status = cau_pkg::ST_OK;
    case (w.operation)
      cau_pkg::OP_ADD: begin
        r.result_real = clip(a + c, sat);
        r.result_imag = clip(b + d, sat);
      end
      cau_pkg::OP_SUB: begin
        r.result_real = clip(a - c, sat);
        r.result_imag = clip(b - d, sat);
      end
      cau_pkg::OP_MUL: begin
        r.result_real = clip((a * c - b * d) >>> cau_pkg::FRAC_BITS, sat);
        r.result_imag = clip((a * d + b * c) >>> cau_pkg::FRAC_BITS, sat);
      end
      cau_pkg::OP_DIV: begin
        den = c * c + d * d;
        if (den == 0) begin
          r.status = cau_pkg::ST_DIVZERO;
        end else begin
          r.result_real = scaled_quotient(a * c + b * d, den, sat);
          r.result_imag = scaled_quotient(b * c - a * d, den, sat);
        end
      end
      cau_pkg::OP_DIST: begin
        dx = a - c;
        dy = b - d;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx >= 128'sd2147483648 || dy >= 128'sd2147483648) begin
          r.result_real = 32'h7FFF_FFFF;
          sat = 1'b1;
        end else begin
          root = int_sqrt(64'(dx * dx + dy * dy));
          if (root > 64'h7FFF_FFFF) begin
            root = 64'h7FFF_FFFF;
            sat = 1'b1;
          end
          r.result_real = root[31:0];
        end
      end
      default: ;
    endcase
    if (sat && r.status == cau_pkg::ST_OK) r.status = cau_pkg::ST_SAT;
    return r;
  endfunction

  function automatic cau_pkg::in_word_t make_word(input logic [31:0] a,
                                                  input logic [31:0] b,
                                                  input logic [31:0] c,
                                                  input logic [31:0] d,
                                                  input logic [2:0] op);
    cau_pkg::in_word_t w;
    w.first_real = a;
    w.first_imag = b;
    w.second_real = c;
    w.second_imag = d;
    w.operation = op;
    return w;
  endfunction

  function automatic logic [31:0] random_part();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      3, 4: return 32'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
      5, 6: return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input cau_pkg::in_word_t w);
    int gap;
    gap = quiet ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_result(w));
    words_sent++;
    op_count[w.operation]++;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("mismatch at %0t: %s expected %h got %h", $realtime, field, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    cau_pkg::out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", '0, out_word.result_real);
      end else begin
        exp_w = expected_results.pop_front();
        if (out_word.result_real !== exp_w.result_real)
          report_mismatch("result_real", exp_w.result_real, out_word.result_real);
        if (out_word.result_imag !== exp_w.result_imag)
          report_mismatch("result_imag", exp_w.result_imag, out_word.result_imag);
        if (out_word.status !== exp_w.status)
          report_mismatch("status", 32'(exp_w.status), 32'(out_word.status));
      end
    end
  end

  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = quiet ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14));
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic test_add_sub();
    send_word(make_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                        cau_pkg::OP_ADD));
    send_word(make_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        cau_pkg::OP_ADD));
    send_word(make_word(32'h0001_8000, 32'hFFFF_0000, 32'h0000_4000, 32'h0002_0000,
                        cau_pkg::OP_ADD));
    send_word(make_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                        cau_pkg::OP_SUB));
    send_word(make_word(32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
                        cau_pkg::OP_SUB));
  endtask

  task automatic test_multiply();
    send_word(make_word(32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000,
                        cau_pkg::OP_MUL));
    send_word(make_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        cau_pkg::OP_MUL));
    send_word(make_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        cau_pkg::OP_MUL));
    send_word(make_word(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000,
                        cau_pkg::OP_MUL));
  endtask

  task automatic test_divide();
    send_word(make_word(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                        cau_pkg::OP_DIV));
    send_word(make_word(32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                        cau_pkg::OP_DIV));
    send_word(make_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000,
                        cau_pkg::OP_DIV));
    send_word(make_word(32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
                        cau_pkg::OP_DIV));
    send_word(make_word(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000,
                        cau_pkg::OP_DIV));
    send_word(make_word(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                        cau_pkg::OP_DIV));
  endtask

  task automatic test_distance();
    send_word(make_word(32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 32'h0000_0000,
                        cau_pkg::OP_DIST));
    send_word(make_word(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000,
                        cau_pkg::OP_DIST));
    send_word(make_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                        cau_pkg::OP_DIST));
    send_word(make_word(32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005,
                        cau_pkg::OP_DIST));
  endtask

  task automatic test_spare_codes();
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_word(make_word($urandom(), $urandom(), $urandom(), $urandom(), 3'(op)));
  endtask

  task automatic test_random_stream();
    logic [2:0] op;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
      op = ($urandom_range(0, 19) == 0)
           ? 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST))
           : 3'($urandom_range(cau_pkg::OP_ADD, cau_pkg::OP_DIST));
      send_word(make_word(random_part(), random_part(), random_part(), random_part(), op));
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    quiet = 1'b1;
    test_add_sub();
    quiet = 1'b0;
    test_multiply();
    test_divide();
    test_distance();
    test_spare_codes();
    test_random_stream();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words: add %0d, sub %0d, mul %0d, div %0d, dist %0d, spare %0d",
             words_sent, op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
             op_count[5] + op_count[6] + op_count[7]);
    $display("%0d results checked with random gaps and stalls on both sides", results_seen);
    if (errors == 0) begin
      $display("complex_arith_unit_tb: done, clean");
    end else begin
      $display("complex_arith_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_cell.sv
rtl/cau_back.sv
rtl/complex_arith_unit.sv
tb/complex_arith_unit_tb.sv
